@@ design/mwpo_pkg.sv @@
package mwpo_pkg;

  // default geometry
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;
  localparam int SAMPLE_BITS_DEF      = 16;

  // configuration register map
  localparam int                 CFG_INDEX_BITS   = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INC   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SELECT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_WIDTH = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_PHASE = 2'd3;

  localparam int CFG_DATA_BITS = 32;

  // register widths and reset values
  localparam int PHASE_INC_BITS   = 31;
  localparam int WAVE_SEL_BITS    = 3;
  localparam int PULSE_WIDTH_BITS = 16;
  localparam int START_PHASE_BITS = 32;

  localparam logic [PHASE_INC_BITS-1:0]   PHASE_INC_RST   = 31'd42852281;
  localparam logic [WAVE_SEL_BITS-1:0]    WAVE_SEL_RST    = 3'd0;
  localparam logic [PULSE_WIDTH_BITS-1:0] PULSE_WIDTH_RST = 16'd32768;
  localparam logic [START_PHASE_BITS-1:0] START_PHASE_RST = 32'd0;

  // waveform codes
  localparam logic [WAVE_SEL_BITS-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_SEL_BITS-1:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [WAVE_SEL_BITS-1:0] WAVE_SAWTOOTH = 3'd2;
  localparam logic [WAVE_SEL_BITS-1:0] WAVE_SQUARE   = 3'd3;
  localparam logic [WAVE_SEL_BITS-1:0] WAVE_NOISE    = 3'd4;

  // noise generator, galois form shifting right
  localparam int          LFSR_BITS = 32;
  localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // quarter-wave sine entry k of a table with 2^qlog2 steps per quarter,
  // taylor series to degree 15 in q30, scaled to full positive amplitude
  function automatic longint sine_entry(input longint k, input int qlog2,
                                        input int sample_bits);
    longint amp;
    longint x;
    longint term;
    longint sum;
    longint r;
    amp  = (longint'(1) <<< (sample_bits - 1)) - 1;
    x    = (HALF_PI_Q30 * k) >>> qlog2;
    term = x;
    sum  = x;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 6;
    sum  = sum - term;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 20;
    sum  = sum + term;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 42;
    sum  = sum - term;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 72;
    sum  = sum + term;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 110;
    sum  = sum - term;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 156;
    sum  = sum + term;
    term = (((term * x) >>> 30) * x) >>> 30;
    term = term / 210;
    sum  = sum - term;
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum * amp + (longint'(1) <<< 29)) >>> 30;
    if (r > amp) begin
      r = amp;
    end
    return r;
  endfunction

endpackage

@@ design/multi_waveform_phase_oscillator_core.sv @@
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    restart_i, block_last_i
// out      output     out_valid_o / out_stall_i  sample_o, last_o
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Two register stages: an accepted item is held in the first stage, then registered into the output stage.
// One item per cycle sustained while the output is not stalled; phase add, sine rom read
// and wave shaping are done in the first stage, negation and output select in the second.
// Reset loads the register defaults, clears the phase and seeds the noise lfsr.
// A stall on the output holds the result; the first stage still takes an item while it is empty.
module multi_waveform_phase_oscillator_core #(
  parameter int SINE_TABLE_DEPTH = mwpo_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = mwpo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS      = mwpo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                restart_i,
  input  logic                                block_last_i,
  // sample channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_o,
  output logic                                last_o,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int TAB_LOG2 = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int QUARTER  = 1 << (TAB_LOG2 - 2);
  localparam int ADDR_W   = TAB_LOG2 - 1;
  localparam int SB       = SAMPLE_BITS;
  localparam int PB       = PHASE_BITS;

  // configuration registers
  logic [mwpo_pkg::PHASE_INC_BITS-1:0]   phase_inc_q;
  logic [mwpo_pkg::WAVE_SEL_BITS-1:0]    wave_sel_q;
  logic [mwpo_pkg::PULSE_WIDTH_BITS-1:0] pulse_width_q;
  logic [mwpo_pkg::START_PHASE_BITS-1:0] start_phase_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q   <= mwpo_pkg::PHASE_INC_RST;
      wave_sel_q    <= mwpo_pkg::WAVE_SEL_RST;
      pulse_width_q <= mwpo_pkg::PULSE_WIDTH_RST;
      start_phase_q <= mwpo_pkg::START_PHASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mwpo_pkg::REG_PHASE_INC:
          phase_inc_q <= cfg_data_i[mwpo_pkg::PHASE_INC_BITS-1:0];
        mwpo_pkg::REG_WAVE_SELECT:
          wave_sel_q <= cfg_data_i[mwpo_pkg::WAVE_SEL_BITS-1:0];
        mwpo_pkg::REG_PULSE_WIDTH:
          pulse_width_q <= cfg_data_i[mwpo_pkg::PULSE_WIDTH_BITS-1:0];
        mwpo_pkg::REG_START_PHASE:
          start_phase_q <= cfg_data_i[mwpo_pkg::START_PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // quarter-wave sine rom, QUARTER+1 entries, all non-negative
  logic [SB-2:0] sine_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    localparam logic [SB-2:0] Entry =
      (SB-1)'(mwpo_pkg::sine_entry(longint'(k), TAB_LOG2 - 2, SB));
    assign sine_rom[k] = Entry;
  end

  // handshake
  logic a_valid_q;
  logic b_valid_q;
  logic a_ready;
  logic b_ready;
  logic accept_in;
  logic a_move;

  assign b_ready    = !b_valid_q || !out_stall_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;
  assign accept_in  = in_valid_i && a_ready;
  assign a_move     = a_valid_q && b_ready;

  // first stage: phase select and waveform shaping
  logic [PB-1:0]           phase_acc_q;
  logic [PB-1:0]           phase_acc_d;
  logic [PB-1:0]           p;
  logic [PB+SB:0]          p_shl;
  logic [31:0]             lfsr_q;
  logic [31:0]             lfsr_d;
  logic [31:0]             lfsr_next;
  logic [TAB_LOG2-1:0]     sine_idx;
  logic [ADDR_W-1:0]       sine_off;
  logic [ADDR_W-1:0]       rom_addr;
  logic [SB:0]             tw_w;
  logic signed [SB+1:0]    tw_mid;
  logic [SB-1:0]           tw_val;
  logic [SB-1:0]           saw_val;
  logic [SB-1:0]           sq_val;
  logic [SB-1:0]           other_d;
  logic                    is_sine_d;
  logic                    advance;

  assign p        = restart_i ? PB'(start_phase_q) : phase_acc_q;
  assign p_shl    = {p, (SB+1)'(0)};
  assign sine_idx = p[PB-1 -: TAB_LOG2];
  assign sine_off = {1'b0, sine_idx[TAB_LOG2-3:0]};
  // odd quadrants run the table backwards
  assign rom_addr = sine_idx[TAB_LOG2-2] ? (ADDR_W'(QUARTER) - sine_off) : sine_off;

  assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? mwpo_pkg::LFSR_TAPS : 32'd0);

  // triangle: rising, falling through the middle half, rising again
  assign tw_w   = p_shl[PB+SB:PB];
  assign tw_mid = $signed({2'b01, SB'(0)}) - $signed({1'b0, tw_w});

  always_comb begin
    case (tw_w[SB:SB-1])
      2'b00, 2'b11: tw_val = tw_w[SB-1:0];
      default: begin
        if (tw_mid == $signed({3'b001, (SB-1)'(0)})) begin
          tw_val = {1'b0, {(SB-1){1'b1}}};
        end else begin
          tw_val = tw_mid[SB-1:0];
        end
      end
    endcase
  end

  assign saw_val = {~p_shl[PB+SB], p_shl[PB+SB-1:PB+1]};
  assign sq_val  = (p[PB-1 -: 16] < pulse_width_q) ? {1'b0, {(SB-1){1'b1}}}
                                                    : {1'b1, (SB-1)'(0)};

  always_comb begin
    other_d   = '0;
    is_sine_d = 1'b0;
    advance   = 1'b1;
    lfsr_d    = lfsr_q;
    case (wave_sel_q)
      mwpo_pkg::WAVE_TRIANGLE: other_d = tw_val;
      mwpo_pkg::WAVE_SAWTOOTH: other_d = saw_val;
      mwpo_pkg::WAVE_SQUARE:   other_d = sq_val;
      mwpo_pkg::WAVE_NOISE: begin
        lfsr_d  = lfsr_next;
        other_d = lfsr_next[31 -: SB];
        advance = 1'b0;
      end
      default: is_sine_d = 1'b1;
    endcase
    phase_acc_d = advance ? (p + PB'(phase_inc_q)) : p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q <= '0;
      lfsr_q      <= mwpo_pkg::LFSR_SEED;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
    end else begin
      if (accept_in) begin
        phase_acc_q <= phase_acc_d;
        lfsr_q      <= lfsr_d;
      end
      if (accept_in) begin
        a_valid_q <= 1'b1;
      end else if (b_ready) begin
        a_valid_q <= 1'b0;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  // stage payload
  logic          a_sine_q;
  logic          a_neg_q;
  logic [SB-2:0] a_rom_q;
  logic [SB-1:0] a_other_q;
  logic          a_last_q;
  logic [SB-1:0] rom_ext;
  logic [SB-1:0] sample_d;
  logic [SB-1:0] sample_q;
  logic          last_q;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      a_sine_q  <= is_sine_d;
      a_neg_q   <= sine_idx[TAB_LOG2-1];
      a_rom_q   <= sine_rom[rom_addr];
      a_other_q <= other_d;
      a_last_q  <= block_last_i;
    end
  end

  // second stage: sign of the lower half cycle, waveform select
  assign rom_ext  = {1'b0, a_rom_q};
  assign sample_d = a_sine_q ? (a_neg_q ? (SB'(0) - rom_ext) : rom_ext) : a_other_q;

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      sample_q <= sample_d;
      last_q   <= a_last_q;
    end
  end

  assign out_valid_o = b_valid_q;
  assign sample_o    = $signed(sample_q);
  assign last_o      = last_q;

endmodule

@@ tb/sv/mwpo_sample_checker.sv @@
`timescale 1ns / 1ps

module mwpo_sample_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                restart_i,
  input  logic                                block_last_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [15:0]                  sample_i,
  input  logic                                last_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [mwpo_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output int                                  pending_o,
  output int                                  fails_o
);

  localparam int FULL_SCALE = 1 << (mwpo_pkg::SAMPLE_BITS_DEF - 1);
  localparam int QUARTER    = 256;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } osc_sample_t;

  osc_sample_t expected_samples[$];
  longint      sine_quarter[0:QUARTER];

  logic [30:0] step_inc;
  logic [2:0]  wave_sel;
  logic [15:0] pulse_w;
  logic [31:0] start_ph;
  logic [31:0] phase;
  logic [31:0] lfsr;
  int          fail_count = 0;

  // taylor series of sin(pi/2 * k/QUARTER) in q30, truncating at each step
  function automatic longint quarter_entry(input longint k);
    longint amp;
    longint x;
    longint term;
    longint sum;
    longint r;
    amp  = FULL_SCALE - 1;
    x    = (mwpo_pkg::HALF_PI_Q30 * k) / QUARTER;
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    r = (sum * amp + (longint'(1) <<< 29)) >>> 30;
    if (r > amp) r = amp;
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= QUARTER; k++) sine_quarter[k] = quarter_entry(k);
  end

  // forms one sample and moves phase and noise state on
  function automatic osc_sample_t next_sample(input logic restart, input logic blast);
    logic [31:0] p;
    logic [9:0]  idx;
    logic [8:0]  r;
    logic [16:0] w;
    int          v;
    logic        advance;
    osc_sample_t res;
    advance = 1'b1;
    if (restart) phase = start_ph;
    p = phase;
    case (wave_sel)
      mwpo_pkg::WAVE_TRIANGLE: begin
        w = p[31:15];
        if (int'(w) < FULL_SCALE) v = int'(w);
        else if (int'(w) < 3 * FULL_SCALE) v = 2 * FULL_SCALE - int'(w);
        else v = int'(w) - 4 * FULL_SCALE;
      end
      mwpo_pkg::WAVE_SAWTOOTH: v = int'(p[31:16]) - FULL_SCALE;
      mwpo_pkg::WAVE_SQUARE:   v = (p[31:16] < pulse_w) ? FULL_SCALE - 1 : -FULL_SCALE;
      mwpo_pkg::WAVE_NOISE: begin
        lfsr = lfsr[0] ? ({1'b0, lfsr[31:1]} ^ mwpo_pkg::LFSR_TAPS) : {1'b0, lfsr[31:1]};
        v = int'($signed(lfsr[31:16]));
        advance = 1'b0;
      end
      default: begin
        // sine, also for custom and the spare codes
        idx = p[31:22];
        r = {1'b0, idx[7:0]};
        if (idx[8]) r = 9'(QUARTER) - r;
        v = int'(sine_quarter[r]);
        if (idx[9]) v = -v;
      end
    endcase
    if (v > FULL_SCALE - 1) v = FULL_SCALE - 1;
    if (v < -FULL_SCALE) v = -FULL_SCALE;
    if (advance) phase = p + {1'b0, step_inc};
    res.sample = v[15:0];
    res.last   = blast;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    osc_sample_t want;
    if (!rst_ni) begin
      step_inc  = mwpo_pkg::PHASE_INC_RST;
      wave_sel  = mwpo_pkg::WAVE_SEL_RST;
      pulse_w   = mwpo_pkg::PULSE_WIDTH_RST;
      start_ph  = mwpo_pkg::START_PHASE_RST;
      phase     = '0;
      lfsr      = mwpo_pkg::LFSR_SEED;
      expected_samples.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected sample, expected none, got %0d", $time, sample_i);
        end else begin
          want = expected_samples.pop_front();
          if (sample_i !== want.sample) begin
            fail_count++;
            $display("%0t: sample mismatch, expected %0d, got %0d", $time,
                     $signed(want.sample), sample_i);
          end
          if (last_i !== want.last) begin
            fail_count++;
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, last_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_samples.push_back(next_sample(restart_i, block_last_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mwpo_pkg::REG_PHASE_INC:   step_inc = cfg_data_i[30:0];
          mwpo_pkg::REG_WAVE_SELECT: wave_sel = cfg_data_i[2:0];
          mwpo_pkg::REG_PULSE_WIDTH: pulse_w  = cfg_data_i[15:0];
          mwpo_pkg::REG_START_PHASE: start_ph = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= expected_samples.size();
    end
    fails_o <= fail_count;
  end

endmodule

@@ tb/sv/tb_multi_waveform_phase_oscillator_core.sv @@
`timescale 1ns / 1ps

module tb_multi_waveform_phase_oscillator_core;

  localparam logic [mwpo_pkg::WAVE_SEL_BITS-1:0] WAVE_CUSTOM = 3'd5;
  localparam logic [mwpo_pkg::WAVE_SEL_BITS-1:0] WAVE_SPARE6 = 3'd6;
  localparam logic [mwpo_pkg::WAVE_SEL_BITS-1:0] WAVE_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 900;

  logic                                clk_i        = 1'b0;
  logic                                rst_n        = 1'b0;
  logic                                in_valid     = 1'b0;
  logic                                in_stall;
  logic                                restart      = 1'b0;
  logic                                block_last   = 1'b0;
  logic                                out_valid;
  logic                                out_stall    = 1'b0;
  logic signed [15:0]                  sample;
  logic                                last;
  logic                                cfg_valid    = 1'b0;
  logic                                cfg_ready;
  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [mwpo_pkg::CFG_DATA_BITS-1:0]  cfg_data     = '0;
  int                                  pending;
  int                                  fails;
  int                                  cycles       = 0;
  logic                                quiet        = 1'b0;
  logic                                sender_idles = 1'b1;
  logic                                recv_idles   = 1'b1;
  logic                                hold_req     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  multi_waveform_phase_oscillator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .restart_i   (restart),
    .block_last_i(block_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .sample_o    (sample),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mwpo_sample_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .restart_i   (restart),
    .block_last_i(block_last),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .sample_i    (sample),
    .last_i      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sample sink: random stall bursts, one long hold on request
  initial begin
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk_i);
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else if (!quiet && recv_idles && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  task automatic send_req(input logic rs, input logic bl);
    in_valid   <= 1'b1;
    restart    <= rs;
    block_last <= bl;
    do @(posedge clk_i); while (in_stall);
    if (!quiet && sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mwpo_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mwpo_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // waits for the pipe to empty, then writes the registers flagged in which
  task automatic configure(input logic [3:0] which, input logic [31:0] inc,
                           input logic [31:0] wave, input logic [31:0] pw,
                           input logic [31:0] start);
    drain();
    if (which[0]) write_reg(mwpo_pkg::REG_PHASE_INC, inc);
    if (which[1]) write_reg(mwpo_pkg::REG_WAVE_SELECT, wave);
    if (which[2]) write_reg(mwpo_pkg::REG_PULSE_WIDTH, pw);
    if (which[3]) write_reg(mwpo_pkg::REG_START_PHASE, start);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          total;
    int          n;
    logic        pressured;
    logic [31:0] inc;
    logic [31:0] wave;
    logic [31:0] pw;
    logic [31:0] start;
    total     = 0;
    pressured = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // defaults after reset
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);
    // quarter-cycle steps hit every quadrant edge of the sine table
    configure(4'b1111, 32'h4000_0000, 32'(mwpo_pkg::WAVE_SINE), 32'd0, 32'd0);
    send_req(1'b1, 1'b0);
    repeat (4) send_req(1'b0, 1'b0);
    // triangle peak at a quarter cycle saturates
    configure(4'b0010, 32'd0, 32'(mwpo_pkg::WAVE_TRIANGLE), 32'd0, 32'd0);
    send_req(1'b1, 1'b0);
    repeat (3) send_req(1'b0, 1'b1);
    configure(4'b1010, 32'h4000_0000, 32'(mwpo_pkg::WAVE_SAWTOOTH), 32'd0, 32'hFFFF_FFFF);
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b0);
    // square with zero and full pulse width
    configure(4'b1110, 32'd0, 32'(mwpo_pkg::WAVE_SQUARE), 32'd0, 32'd0);
    send_req(1'b1, 1'b0);
    configure(4'b0100, 32'd0, 32'd0, 32'h0000_FFFF, 32'd0);
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b0);
    // noise: restart loads start phase but the phase does not move
    configure(4'b1010, 32'd0, 32'(mwpo_pkg::WAVE_NOISE), 32'd0, 32'h1234_5678);
    send_req(1'b1, 1'b0);
    send_req(1'b0, 1'b0);
    configure(4'b0010, 32'd0, 32'(WAVE_CUSTOM), 32'd0, 32'd0);
    send_req(1'b0, 1'b0);
    configure(4'b0010, 32'd0, 32'(WAVE_SPARE6), 32'd0, 32'd0);
    send_req(1'b0, 1'b0);
    configure(4'b0010, 32'd0, 32'(WAVE_SPARE7), 32'd0, 32'd0);
    send_req(1'b0, 1'b1);
    // zero increment after masking holds the phase, then the largest step
    configure(4'b0011, 32'h8000_0000, 32'(mwpo_pkg::WAVE_SAWTOOTH), 32'd0, 32'd0);
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b0);
    configure(4'b0001, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_req(1'b0, 1'b0);
    send_req(1'b0, 1'b1);

    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 6))
        0:       inc = 32'd1947831;
        1:       inc = 32'd1947830963;
        2:       inc = 32'd0;
        3:       inc = 32'hFFFF_FFFF;
        4:       inc = $urandom();
        default: inc = $urandom_range(1947831, 1947830963);
      endcase
      wave = ($urandom_range(0, 5) == 0) ? $urandom() : 32'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0:       pw = 32'd0;
        1:       pw = 32'd655;
        2:       pw = 32'd64880;
        3:       pw = 32'h0000_FFFF;
        4:       pw = $urandom();
        default: pw = $urandom_range(655, 64880);
      endcase
      case ($urandom_range(0, 3))
        0:       start = 32'd0;
        1:       start = 32'hFFFF_FFFF;
        default: start = $urandom();
      endcase
      configure(4'($urandom_range(1, 15)), inc, wave, pw, start);
      sender_idles = ($urandom_range(0, 3) != 0);
      recv_idles   = ($urandom_range(0, 3) != 0);
      if (total >= RANDOM_ITEMS - 120) quiet = 1'b1;
      n = $urandom_range(10, 60);
      if (!pressured && total >= 200) begin
        // long sink hold while requests keep coming fills the pipe
        pressured    = 1'b1;
        hold_req     = 1'b1;
        sender_idles = 1'b0;
        n            = 60;
      end
      repeat (n) begin
        send_req($urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
        total++;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mwpo_pkg.sv
design/multi_waveform_phase_oscillator_core.sv
tb/sv/mwpo_sample_checker.sv
tb/sv/tb_multi_waveform_phase_oscillator_core.sv
